// File: hdl/cvfd_pkg.sv
`default_nettype none

package cvfd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned MV_W = 13;
  localparam int unsigned RAW_W = 12;
  localparam int unsigned CELL_W = 4;
  localparam int unsigned MAX_CELLS = 10;

  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
  localparam logic [BYTE_W-1:0] TOP_OFFSET_RESET = 8'd92;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic [PADDR_W-1:0] ADDR_TOP_CELL_OFFSET = 3'd0;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              frame_start;
    logic              spi_timeout;
  } in_word_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_index;
    logic [MV_W-1:0]   cell_millivolts;
    logic              voltage_valid;
    logic              check_error;
    logic              last;
  } out_word_t;

  // Command from the frame sequencer to the bit-serial CRC unit.
  typedef struct packed {
    logic              load;
    logic              clear;
    logic [BYTE_W-1:0] data;
  } crc_cmd_t;

endpackage

`default_nettype wire

// File: hdl/cvfd_crc.sv
`default_nettype none

module cvfd_crc (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cvfd_pkg::crc_cmd_t          cmd,
  output logic                             busy,
  output logic [cvfd_pkg::BYTE_W-1:0]      remainder
);

  logic [2:0] bit_cnt;

  // One polynomial step per cycle, eight steps per byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      remainder <= '0;
      busy <= 1'b0;
      bit_cnt <= '0;
    end else if (cmd.load) begin
      remainder <= (cmd.clear ? '0 : remainder) ^ cmd.data;
      busy <= 1'b1;
      bit_cnt <= '0;
    end else if (busy) begin
      if (remainder[cvfd_pkg::BYTE_W-1]) begin
        remainder <= {remainder[cvfd_pkg::BYTE_W-2:0], 1'b0} ^ cvfd_pkg::CRC_POLY;
      end else begin
        remainder <= {remainder[cvfd_pkg::BYTE_W-2:0], 1'b0};
      end
      bit_cnt <= bit_cnt + 3'd1;
      if (bit_cnt == 3'd7) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/cell_voltage_frame_decoder.sv
`default_nettype none

// A data byte stalls the input through its bit-serial CRC and the return to idle; a group's
// two cell scalings use the shared adder meanwhile. A check byte moves the block to the
// emit state, which loads one result a cycle unless the output stalls (up to ten) through
// the shared adder, or one bare last word on an SPI timeout; the input is ready again once
// the last is loaded. Reset (synchronous) clears position, CRC remainder and timeout mark
// and sets the offset to 92 mV; held bytes and the cell store keep whatever they held.
module cell_voltage_frame_decoder #(
  parameter int NUM_DATA_BYTES = 15
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire cvfd_pkg::in_word_t            in_word,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output cvfd_pkg::out_word_t                out_word,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [cvfd_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [cvfd_pkg::PDATA_W-1:0]  pwdata,
  output logic [cvfd_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);

  localparam int PosW = $clog2(NUM_DATA_BYTES + 2);
  localparam logic [PosW-1:0] DataBytes = PosW'(NUM_DATA_BYTES);
  localparam int GroupCells = 2 * (NUM_DATA_BYTES / 3);
  localparam int NumCells = (GroupCells > cvfd_pkg::MAX_CELLS) ?
                            cvfd_pkg::MAX_CELLS : GroupCells;
  localparam logic [cvfd_pkg::CELL_W-1:0] LastCell = cvfd_pkg::CELL_W'(NumCells - 1);
  localparam logic [cvfd_pkg::CELL_W-1:0] CellLimit = cvfd_pkg::CELL_W'(cvfd_pkg::MAX_CELLS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WORK,
    ST_EMIT
  } state_t;

  state_t state;

  logic [cvfd_pkg::BYTE_W-1:0] top_cell_offset;
  logic [PosW-1:0]             byte_position;
  logic [1:0]                  phase;
  logic [cvfd_pkg::CELL_W-1:0] cell_ptr;
  logic                        timeout_seen;
  logic                        group;
  logic [1:0]                  scale_cnt;
  logic [cvfd_pkg::CELL_W-1:0] emit_idx;
  logic                        timeout_mode;
  logic                        check_err;

  logic [cvfd_pkg::BYTE_W-1:0] held_bytes [2];
  logic [cvfd_pkg::BYTE_W-1:0] group_byte;
  logic [cvfd_pkg::MV_W-1:0]   cell_store [cvfd_pkg::MAX_CELLS];

  cvfd_pkg::crc_cmd_t          crc_cmd;
  logic                        crc_busy;
  logic [cvfd_pkg::BYTE_W-1:0] crc_rem;

  logic                        in_accept;
  logic                        out_free;
  logic [PosW-1:0]             pos_eff;
  logic [1:0]                  phase_eff;
  logic [cvfd_pkg::CELL_W-1:0] cell_eff;
  logic                        timeout_eff;
  logic                        is_data;
  logic                        is_check;

  logic [cvfd_pkg::RAW_W-1:0]  lo_raw;
  logic [cvfd_pkg::RAW_W-1:0]  hi_raw;
  logic [cvfd_pkg::RAW_W-1:0]  scale_raw;
  logic [cvfd_pkg::MV_W-1:0]   add_a;
  logic [cvfd_pkg::MV_W-1:0]   add_b;
  logic [cvfd_pkg::MV_W-1:0]   add_sum;
  logic                        scale_step;
  logic                        store_we;

  // Configuration port.
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr == cvfd_pkg::ADDR_TOP_CELL_OFFSET) begin
      prdata = {{(cvfd_pkg::PDATA_W - cvfd_pkg::BYTE_W){1'b0}}, top_cell_offset};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top_cell_offset <= cvfd_pkg::TOP_OFFSET_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == cvfd_pkg::ADDR_TOP_CELL_OFFSET) begin
      top_cell_offset <= pwdata[cvfd_pkg::BYTE_W-1:0];
    end
  end

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // A frame start wipes the frame state before the word itself is taken.
  assign pos_eff     = in_word.frame_start ? '0 : byte_position;
  assign phase_eff   = in_word.frame_start ? 2'd0 : phase;
  assign cell_eff    = in_word.frame_start ? '0 : cell_ptr;
  assign timeout_eff = (in_word.frame_start ? 1'b0 : timeout_seen) | in_word.spi_timeout;
  assign is_data     = pos_eff < DataBytes;
  assign is_check    = pos_eff == DataBytes;

  assign crc_cmd.load  = in_accept && is_data;
  assign crc_cmd.clear = in_word.frame_start;
  assign crc_cmd.data  = in_word.data_byte;

  cvfd_crc u_crc (
    .clk       (clk),
    .rst       (rst),
    .cmd       (crc_cmd),
    .busy      (crc_busy),
    .remainder (crc_rem)
  );

  // Shared adder: r*3/2 is r + r/2 during a group, store (+ offset on the last cell) in the burst.
  assign lo_raw     = {held_bytes[1][3:0], held_bytes[0]};
  assign hi_raw     = {group_byte, held_bytes[1][7:4]};
  assign scale_raw  = (scale_cnt == 2'd0) ? lo_raw : hi_raw;
  assign scale_step = (state == ST_WORK) && group && (scale_cnt != 2'd2);

  always_comb begin
    add_a = '0;
    add_b = '0;
    case (state)
      ST_WORK: begin
        add_a = {1'b0, scale_raw};
        add_b = {2'b00, scale_raw[cvfd_pkg::RAW_W-1:1]};
      end
      ST_EMIT: begin
        add_a = cell_store[emit_idx];
        if (emit_idx == LastCell) begin
          add_b = {{(cvfd_pkg::MV_W - cvfd_pkg::BYTE_W){1'b0}}, top_cell_offset};
        end
      end
      default: begin
        add_a = '0;
        add_b = '0;
      end
    endcase
  end

  assign add_sum  = add_a + add_b;
  assign store_we = scale_step && (cell_ptr < CellLimit);

  always_ff @(posedge clk) begin
    if (store_we) begin
      cell_store[cell_ptr] <= add_sum;
    end
    if (in_accept && is_data) begin
      if (phase_eff == 2'd0) begin
        held_bytes[0] <= in_word.data_byte;
      end
      if (phase_eff == 2'd1) begin
        held_bytes[1] <= in_word.data_byte;
      end
      if (phase_eff == 2'd2) begin
        group_byte <= in_word.data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      byte_position <= '0;
      phase <= 2'd0;
      cell_ptr <= '0;
      timeout_seen <= 1'b0;
      group <= 1'b0;
      scale_cnt <= 2'd0;
      emit_idx <= '0;
      timeout_mode <= 1'b0;
      check_err <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // While emitting, the burst itself decides the next out_valid.
      if (out_valid && !out_stall && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            if (is_data) begin
              byte_position <= pos_eff + PosW'(1);
              timeout_seen <= timeout_eff;
              phase <= (phase_eff == 2'd2) ? 2'd0 : phase_eff + 2'd1;
              cell_ptr <= cell_eff;
              group <= (phase_eff == 2'd2);
              scale_cnt <= 2'd0;
              state <= ST_WORK;
            end else if (is_check) begin
              byte_position <= pos_eff + PosW'(1);
              timeout_seen <= timeout_eff;
              timeout_mode <= timeout_eff;
              check_err <= (crc_rem != in_word.data_byte);
              emit_idx <= '0;
              state <= ST_EMIT;
            end
          end
        end
        ST_WORK: begin
          if (scale_step) begin
            scale_cnt <= scale_cnt + 2'd1;
            if (cell_ptr != CellLimit) begin
              cell_ptr <= cell_ptr + cvfd_pkg::CELL_W'(1);
            end
          end else if (!crc_busy) begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_word.check_error <= check_err;
            if (timeout_mode) begin
              out_word.cell_index <= '0;
              out_word.cell_millivolts <= '0;
              out_word.voltage_valid <= 1'b0;
              out_word.last <= 1'b1;
              state <= ST_IDLE;
            end else begin
              out_word.cell_index <= emit_idx;
              out_word.cell_millivolts <= add_sum;
              out_word.voltage_valid <= 1'b1;
              out_word.last <= (emit_idx == LastCell);
              if (emit_idx == LastCell) begin
                state <= ST_IDLE;
              end else begin
                emit_idx <= emit_idx + cvfd_pkg::CELL_W'(1);
              end
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
